// ===== sv/bffe_pkg.sv =====
// ----------------------------------------------------------------------------
// bffe_pkg
// Shared constants, types and bit search helpers of the bitmap engine.
// ----------------------------------------------------------------------------
package bffe_pkg;

    localparam int CAPACITY_BITS = 1024;
    localparam int WORD_BITS     = 32;
    localparam int NUM_WORDS     = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W         = $clog2(CAPACITY_BITS);
    localparam int CNT_W         = $clog2(CAPACITY_BITS + 1);
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int WADDR_W       = $clog2(NUM_WORDS);
    localparam int OP_W          = 3;

    localparam logic [OP_W-1:0] OP_GET   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET   = 3'd1;
    localparam logic [OP_W-1:0] OP_UNSET = 3'd2;
    localparam logic [OP_W-1:0] OP_FLIP  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MOD, ST_RFIRST, ST_RLAST, ST_RUNSET, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_INPUT, RD_FIRST, RD_LAST, RD_UNSET
    } rd_sel_t;

    typedef struct packed {
        logic    latch_in;
        logic    mod_en;
        logic    cap_first;
        logic    cap_last;
        logic    load_out;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
            if (v[i]) r = BIT_W'(i);
        return r;
    endfunction

    function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++)
            if (v[i]) r = BIT_W'(i);
        return r;
    endfunction

    function automatic logic [WADDR_W-1:0] low_word(input logic [NUM_WORDS-1:0] v);
        logic [WADDR_W-1:0] r;
        r = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
            if (v[i]) r = WADDR_W'(i);
        return r;
    endfunction

    function automatic logic [WADDR_W-1:0] high_word(input logic [NUM_WORDS-1:0] v);
        logic [WADDR_W-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_WORDS; i++)
            if (v[i]) r = WADDR_W'(i);
        return r;
    endfunction

endpackage

// ===== sv/bffe_ram.sv =====
// ----------------------------------------------------------------------------
// bffe_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bffe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bffe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bffe_ctrl
// Sequencer: modify one word, then read back the three summary words.
// ----------------------------------------------------------------------------
module bffe_ctrl
    import bffe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_INPUT;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
                if (s_tvalid)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_en = 1'b1;
                state_next = ST_RFIRST;
            end
            ST_RFIRST:
            begin
                cmd.rd_sel = RD_FIRST;
                state_next = ST_RLAST;
            end
            ST_RLAST:
            begin
                cmd.rd_sel    = RD_LAST;
                cmd.cap_first = 1'b1;
                state_next    = ST_RUNSET;
            end
            ST_RUNSET:
            begin
                cmd.rd_sel   = RD_UNSET;
                cmd.cap_last = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // keep reading the same word while the output is busy
                cmd.rd_sel = RD_UNSET;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/bffe_dp.sv =====
// ----------------------------------------------------------------------------
// bffe_dp
// Word store, per-word summary flags, set count and result register.
// ----------------------------------------------------------------------------
module bffe_dp
    import bffe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [OP_W-1:0]      in_operation,
    input  logic [IDX_W-1:0]     in_bit_index,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [47:0]          m_tdata
);

    logic [OP_W-1:0]      op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [NUM_WORDS-1:0] vld_reg, nz_reg, full_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 old_reg, err_reg;
    logic [IDX_W-1:0]     first_reg, last_reg;
    logic [WADDR_W-1:0]   raddr_q_reg;
    logic                 m_tvalid_reg;
    logic [47:0]          m_tdata_reg;

    logic [WADDR_W-1:0]   raddr, waddr;
    logic [WORD_BITS-1:0] ram_q, cur, new_word;
    logic [BIT_W-1:0]     sh;
    logic                 err, we, cur_bit, new_bit;
    logic                 any_set;
    logic [CNT_W-1:0]     first_unset;

    assign waddr = idx_reg[IDX_W-1:BIT_W];
    assign sh    = idx_reg[BIT_W-1:0];
    assign err   = {1'b0, idx_reg} >= (IDX_W+1)'(CAPACITY_BITS);
    assign cur   = vld_reg[raddr_q_reg] ? ram_q : '0;
    assign cur_bit = cur[sh];
    assign any_set = |nz_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_INPUT: raddr = in_bit_index[IDX_W-1:BIT_W];
            RD_FIRST: raddr = low_word(nz_reg);
            RD_LAST:  raddr = high_word(nz_reg);
            RD_UNSET: raddr = low_word(~full_reg);
            default:  raddr = '0;
        endcase
    end

    always_comb
    begin
        new_word = cur;
        we       = 1'b0;
        case (op_reg)
            OP_SET:   begin new_word[sh] = 1'b1;     we = 1'b1; end
            OP_UNSET: begin new_word[sh] = 1'b0;     we = 1'b1; end
            OP_FLIP:  begin new_word[sh] = ~cur_bit; we = 1'b1; end
            default:  we = 1'b0;
        endcase
        we      = we && cmd.mod_en && !err;
        new_bit = new_word[sh];
    end

    always_comb
    begin
        if (&full_reg)
            first_unset = CNT_W'(CAPACITY_BITS);
        else
            first_unset = CNT_W'({low_word(~full_reg), low_bit(~cur)});
    end

    bffe_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (new_word),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            nz_reg       <= '0;
            full_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mod_en && op_reg == OP_CLEAR)
            begin
                vld_reg   <= '0;
                nz_reg    <= '0;
                full_reg  <= '0;
                count_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr]  <= 1'b1;
                nz_reg[waddr]   <= |new_word;
                full_reg[waddr] <= &new_word;
                count_reg <= count_reg + CNT_W'(new_bit) - CNT_W'(cur_bit);
            end
            if (cmd.load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_q_reg <= raddr;
        if (cmd.latch_in)
        begin
            op_reg  <= in_operation;
            idx_reg <= in_bit_index;
        end
        if (cmd.mod_en)
        begin
            err_reg <= (op_reg != OP_CLEAR) && err;
            old_reg <= (op_reg != OP_CLEAR) && !err && cur_bit;
        end
        if (cmd.cap_first)
            first_reg <= any_set ? {raddr_q_reg, low_bit(cur)} : '0;
        if (cmd.cap_last)
            last_reg <= any_set ? {raddr_q_reg, high_bit(cur)} : '0;
        if (cmd.load_out)
            m_tdata_reg <= {3'b000, first_unset, last_reg, first_reg,
                            count_reg, any_set, err_reg, old_reg};
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/bitmap_find_first_engine_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_find_first_engine_core
// 1024-bit bitmap with get/set/unset/flip/clear and find-first summaries.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per command (operation, bit_index).
// Output stream m_*: one word per command with the old bit, range error and
// a summary of the bitmap after the command (any set, count, first set,
// last set, first unset; first unset equals the capacity when full).
// One command is in flight at a time: accept, a read-modify-write of the
// addressed word in the word store, then three reads of the summary words
// on the one read port (first set, last set, first unset); a new command
// is taken only after the previous one has loaded its result.
// The result sits in an output register; the next command is accepted
// while it waits, and its own result holds in the last step until the
// register frees up. Reset clears the whole bitmap at once through per-word
// valid flags, so no clearing pass is needed and commands are taken right
// away. Clear-all resets the same flags in its modify step.
// ----------------------------------------------------------------------------
module bitmap_find_first_engine_core
    import bffe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[2:0], bit_index[12:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // old_bit[0], index_error[1], any_set[2],
                                   // set_count[13:3], first_set[23:14],
                                   // last_set[33:24], first_unset[44:34], pad
);

    cmd_t    cmd;
    status_t status;

    bffe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bffe_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_operation (s_tdata[OP_W-1:0]),
        .in_bit_index (s_tdata[OP_W+IDX_W-1:OP_W]),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

endmodule
